### sv/fast_exp_float32_unit_macros.svh
// Assertion macros for the fast exponential unit.
// Each macro expands to a labeled concurrent assertion clocked on clk and
// disabled while rst_n is low. With SYNTH defined they expand to nothing.
`ifndef FAST_EXP_FLOAT32_UNIT_MACROS_SVH
`define FAST_EXP_FLOAT32_UNIT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define FEU_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fast_exp_float32_unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define FEU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fast_exp_float32_unit: next-cycle check failed");

`else

`define FEU_ASSERT_IMPLY(label, ante, cons)
`define FEU_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### sv/fexp_pkg.sv
`timescale 1ns / 1ps

package fexp_pkg;

  // Default configuration.
  localparam int FRAC_BITS_DEF = 24;
  localparam int MID_DEPTH_DEF = 8;
  localparam int OUT_DEPTH_DEF = 16;

  // Constants held as Q2.30 integers.
  localparam logic [63:0] Q30_LOG2E = 64'd1549082005;
  localparam logic [63:0] Q30_C0    = 64'd1073741824;
  localparam logic [63:0] Q30_C1    = 64'd744261118;
  localparam logic [63:0] Q30_C2    = 64'd257941248;
  localparam logic [63:0] Q30_C3    = 64'd59597083;
  localparam logic [63:0] Q30_C4    = 64'd10327387;
  localparam logic [63:0] Q30_C5    = 64'd1431680;

  // Input magnitudes are clamped to this integer value.
  localparam logic [63:0] CLAMP_INT = 64'd88;

  // Float32 field codes and limits.
  localparam logic [7:0] EXP_NAN   = 8'hFF;
  localparam logic [7:0] EXP_CLAMP = 8'd134;  // every exponent from here up clamps
  localparam int         EXP_UNIT  = 150;     // bias plus mantissa width
  localparam logic signed [8:0] EXP_BIAS = 9'sd127;
  localparam logic signed [8:0] N_MIN    = -9'sd126;
  localparam int         MANT_W    = 23;

  // Classification of one item, decided by the front end.
  typedef struct packed {
    logic nan;    // input was a NaN: result is +0
    logic under;  // integer part below the smallest normal exponent
  } fexp_cls_t;

  // Round a Q2.30 constant half up to frac_bits fraction bits.
  function automatic logic [63:0] fexp_to_qf(input logic [63:0] c30, input int frac_bits);
    int s;
    s = 30 - frac_bits;
    if (s == 0) begin
      return c30;
    end
    return (c30 + (64'd1 << (s - 1))) >> s;
  endfunction

endpackage

### sv/fast_exp_float32_unit.sv
// Channel   Direction  Handshake               Payload
// input     in         in_push / in_full       in_x_bits (float32)
// result    out        out_pop / out_empty     out_result_bits (float32), out_underflowed
//
// One item is accepted per cycle while in_full is low; items never wait on each other.
// An accepted item passes through three front stages, the middle queue, eleven back
// stages and the result queue before it shows on the out ports.
// Full rate holds with MID_DEPTH of at least 5 and OUT_DEPTH of at least 13.
// rst_n is synchronous and active low; it empties both queues and all stage valids.
// A stalled out_pop fills the result queue, then the middle queue, then raises in_full.
`timescale 1ns / 1ps

`include "fast_exp_float32_unit_macros.svh"

module fast_exp_float32_unit import fexp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MID_DEPTH = MID_DEPTH_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [31:0] in_x_bits,
  output logic        in_full,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_result_bits,
  output logic        out_underflowed
);

  // The middle queue carries the class, the integer part n and the fraction f.
  localparam int CLS_W = $bits(fexp_cls_t);
  localparam int MID_W = CLS_W + 9 + FRAC_BITS;
  localparam int OUT_W = 33;

  // Front end to middle queue.
  logic                 front_push;
  fexp_cls_t            front_cls;
  logic signed [8:0]    front_n;
  logic [FRAC_BITS-1:0] front_f;

  // Middle queue to back end.
  logic                 mid_pop;
  logic                 mid_empty;
  logic [MID_W-1:0]     mid_rdata;
  fexp_cls_t            mid_cls;
  logic signed [8:0]    mid_n;
  logic [FRAC_BITS-1:0] mid_f;

  // Back end to result queue.
  logic        res_push;
  logic [31:0] res_result_bits;
  logic        res_underflowed;
  logic        out_take;
  logic [OUT_W-1:0] out_rdata;

  // The front end converts x to fixed point, scales it by log2(e), splits it into
  // n and f and flags NaN and underflow. Its credit counter sizes in_full so that
  // every item in flight has a slot waiting in the middle queue.
  fexp_front #(
    .FRAC_BITS (FRAC_BITS),
    .MID_DEPTH (MID_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_x_bits (in_x_bits),
    .in_full   (in_full),
    .mid_pop   (mid_pop),
    .mid_push  (front_push),
    .mid_cls   (front_cls),
    .mid_n     (front_n),
    .mid_f     (front_f)
  );

  fexp_fifo #(
    .WIDTH (MID_W),
    .DEPTH (MID_DEPTH)
  ) u_mid_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (front_push),
    .wdata ({front_cls, front_n, front_f}),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  assign mid_cls = fexp_cls_t'(mid_rdata[MID_W-1 -: CLS_W]);
  assign mid_n   = $signed(mid_rdata[FRAC_BITS +: 9]);
  assign mid_f   = mid_rdata[FRAC_BITS-1:0];

  // The back end evaluates 2^f by Horner's rule, one multiplier per step and a
  // register after each multiply, then packs the float. It only issues an item
  // when a slot in the result queue is reserved for it, so its pipeline never stalls.
  fexp_back #(
    .FRAC_BITS (FRAC_BITS),
    .OUT_DEPTH (OUT_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .mid_empty       (mid_empty),
    .mid_cls         (mid_cls),
    .mid_n           (mid_n),
    .mid_f           (mid_f),
    .mid_pop         (mid_pop),
    .out_take        (out_take),
    .res_push        (res_push),
    .res_result_bits (res_result_bits),
    .res_underflowed (res_underflowed)
  );

  assign out_take = out_pop && !out_empty;

  // The result queue parts the pipeline from the consumer.
  fexp_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata ({res_result_bits, res_underflowed}),
    .pop   (out_take),
    .rdata (out_rdata),
    .empty (out_empty)
  );

  assign out_result_bits = out_rdata[OUT_W-1:1];
  assign out_underflowed = out_rdata[0];

  // e^x is never negative, so the sign bit of a result is always clear.
  `FEU_ASSERT_IMPLY(a_sign_clear, !out_empty, !out_result_bits[31])
  // An underflowed item is delivered as +0.
  `FEU_ASSERT_IMPLY(a_underflow_zero, !out_empty && out_underflowed, out_result_bits == 32'd0)
  // A nonzero result is always a normal number: the zero exponent only comes with underflow or a NaN input.
  `FEU_ASSERT_IMPLY(a_normal_result, !out_empty && |out_result_bits, |out_result_bits[30:23])
  // Credits return only when the back end issues, so full holds until it does.
  `FEU_ASSERT_NEXT(a_full_holds, in_full && !mid_pop, in_full)

endmodule

### sv/fexp_fifo.sv
`timescale 1ns / 1ps

module fexp_fifo import fexp_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  // Pushes are kept in bounds by the credit counters upstream and pops by the empty checks.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign empty = (cnt_r == '0);

endmodule

### sv/fexp_front.sv
`timescale 1ns / 1ps

module fexp_front import fexp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int MID_DEPTH = MID_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic [31:0]          in_x_bits,
  output logic                 in_full,
  input  logic                 mid_pop,
  output logic                 mid_push,
  output fexp_cls_t            mid_cls,
  output logic signed [8:0]    mid_n,
  output logic [FRAC_BITS-1:0] mid_f
);

  localparam int MW    = FRAC_BITS + 7;   // clamped magnitude, up to 88.0
  localparam int LW    = FRAC_BITS + 1;   // log2(e) in QF
  localparam int HW    = MW - 16;         // high part of the magnitude
  localparam int HPW   = HW + LW;
  localparam int LPW   = 16 + LW;
  localparam int SUMW  = HPW + 1;
  localparam int YW    = FRAC_BITS + 7;   // scaled magnitude stays below 127.0
  localparam int CW    = $clog2(MID_DEPTH + 1);

  localparam logic [LW-1:0] LG  = LW'(fexp_to_qf(Q30_LOG2E, FRAC_BITS));
  localparam logic [MW-1:0] LIM = MW'(CLAMP_INT << FRAC_BITS);

  logic          accept;
  logic [CW-1:0] used_r, used_nxt;

  // Stage 1: float to fixed point with clamp.
  logic [7:0]        e, e_eff;
  logic [23:0]       m;
  logic signed [9:0] sh;
  logic [9:0]        rs;
  logic [63:0]       wide;
  logic [MW-1:0]     mag;
  logic              nan;

  logic          v1_r, sign1_r, nan1_r;
  logic [MW-1:0] mag1_r;

  // Stage 2: split multiply by log2(e).
  logic [HW-1:0]  xh;
  logic [15:0]    xl;
  logic [HPW-1:0] hi_prod;
  logic [LPW-1:0] lo_prod;

  logic           v2_r, sign2_r, nan2_r;
  logic [HPW-1:0] hi2_r;
  logic [LW-1:0]  lo2_r;

  // Stage 3: sum and rescale.
  logic [SUMW-1:0] sum;
  logic            v3_r, sign3_r, nan3_r;
  logic [YW-1:0]   ymag3_r;

  // Split into integer part and fraction.
  logic [6:0]           ip;
  logic [FRAC_BITS-1:0] fr;
  logic                 carry;
  logic signed [8:0]    npos;

  assign accept = in_push && !in_full;

  always_comb begin
    e     = in_x_bits[30:23];
    nan   = (e == EXP_NAN) && (in_x_bits[22:0] != '0);
    e_eff = (e == '0) ? 8'd1 : e;
    m     = (e == '0) ? {1'b0, in_x_bits[22:0]} : {1'b1, in_x_bits[22:0]};
    sh    = $signed({2'b00, e_eff}) + $signed(10'(FRAC_BITS - EXP_UNIT));
    rs    = -sh;
    if (!sh[9]) begin
      wide = 64'(m) << sh[5:0];
    end else if (rs[9:6] != '0) begin
      wide = '0;
    end else begin
      wide = 64'(m) >> rs[5:0];
    end
    if (e >= EXP_CLAMP || wide > 64'(LIM)) begin
      mag = LIM;
    end else begin
      mag = wide[MW-1:0];
    end
  end

  always_comb begin
    xh      = mag1_r[MW-1:16];
    xl      = mag1_r[15:0];
    hi_prod = HPW'(xh) * HPW'(LG);
    lo_prod = LPW'(xl) * LPW'(LG);
  end

  assign sum = SUMW'(hi2_r) + SUMW'(lo2_r);

  // A negative y is rounded down, so the fraction is the complement.
  always_comb begin
    ip    = ymag3_r[YW-1:FRAC_BITS];
    fr    = ymag3_r[FRAC_BITS-1:0];
    carry = (fr != '0);
    npos  = $signed({2'b00, ip});
    if (sign3_r) begin
      mid_n = -(npos + $signed({8'd0, carry}));
      mid_f = '0 - fr;
    end else begin
      mid_n = npos;
      mid_f = fr;
    end
    mid_cls.nan   = nan3_r;
    mid_cls.under = !nan3_r && (mid_n < N_MIN);
  end

  assign mid_push = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    mag1_r  <= mag;
    sign1_r <= in_x_bits[31];
    nan1_r  <= nan;
    hi2_r   <= hi_prod;
    lo2_r   <= lo_prod[LPW-1:16];
    sign2_r <= sign1_r;
    nan2_r  <= nan1_r;
    ymag3_r <= sum[FRAC_BITS-16 +: YW];
    sign3_r <= sign2_r;
    nan3_r  <= nan2_r;
  end

  // One credit per queue entry, taken on accept and returned when the back end pops.
  always_comb begin
    used_nxt = used_r;
    if (accept && !mid_pop) begin
      used_nxt = used_r + 1'b1;
    end else if (mid_pop && !accept) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

  assign in_full = (used_r == CW'(MID_DEPTH));

endmodule

### sv/fexp_back.sv
`timescale 1ns / 1ps

module fexp_back import fexp_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int OUT_DEPTH = OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mid_empty,
  input  fexp_cls_t            mid_cls,
  input  logic signed [8:0]    mid_n,
  input  logic [FRAC_BITS-1:0] mid_f,
  output logic                 mid_pop,
  input  logic                 out_take,
  output logic                 res_push,
  output logic [31:0]          res_result_bits,
  output logic                 res_underflowed
);

  localparam int PW    = FRAC_BITS + 2;      // polynomial accumulator
  localparam int PRW   = PW + FRAC_BITS;     // accumulator times fraction
  localparam int NSTEP = 5;                  // Horner steps
  localparam int NST   = 2 * NSTEP + 1;      // issue stage plus multiply and add per step
  localparam int CW    = $clog2(OUT_DEPTH + 1);

  localparam logic [PW-1:0] C5 = PW'(fexp_to_qf(Q30_C5, FRAC_BITS));
  localparam logic [PW-1:0] COEF [NSTEP] = '{
    PW'(fexp_to_qf(Q30_C4, FRAC_BITS)),
    PW'(fexp_to_qf(Q30_C3, FRAC_BITS)),
    PW'(fexp_to_qf(Q30_C2, FRAC_BITS)),
    PW'(fexp_to_qf(Q30_C1, FRAC_BITS)),
    PW'(fexp_to_qf(Q30_C0, FRAC_BITS))
  };
  localparam logic [PW-1:0] PMAX = PW'((64'd1 << (FRAC_BITS + 1)) - 64'd1);

  logic [CW-1:0] used_r, used_nxt;

  logic                 vld_r [NST];
  fexp_cls_t            cls_r [NST];
  logic signed [8:0]    n_r   [NST];
  logic [FRAC_BITS-1:0] f_r   [NST];
  logic [PRW-1:0]       prod_r [NSTEP];
  logic [PW-1:0]        acc_r  [NSTEP];
  logic [PW-1:0]        mul_in [NSTEP];

  logic [PW-1:0]     psat;
  logic [MANT_W-1:0] mant;
  logic [8:0]        bexp;

  // Issue when the result queue has a free slot reserved for this item.
  assign mid_pop = !mid_empty && (used_r < CW'(OUT_DEPTH));

  always_comb begin
    for (int j = 0; j < NSTEP; j++) begin
      mul_in[j] = (j == 0) ? C5 : acc_r[(j == 0) ? 0 : j - 1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NST; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= mid_pop;
      for (int s = 1; s < NST; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  // Step j multiplies in stage 2j+1 and adds its coefficient in stage 2j+2.
  always_ff @(posedge clk) begin
    cls_r[0] <= mid_cls;
    n_r[0]   <= mid_n;
    f_r[0]   <= mid_f;
    for (int s = 1; s < NST; s++) begin
      cls_r[s] <= cls_r[s-1];
      n_r[s]   <= n_r[s-1];
      f_r[s]   <= f_r[s-1];
    end
    for (int j = 0; j < NSTEP; j++) begin
      prod_r[j] <= PRW'(mul_in[j]) * PRW'(f_r[2*j]);
      acc_r[j]  <= COEF[j] + prod_r[j][PRW-1:FRAC_BITS];
    end
  end

  assign psat = (acc_r[NSTEP-1] > PMAX) ? PMAX : acc_r[NSTEP-1];

  generate
    if (FRAC_BITS >= MANT_W) begin : g_mant_trunc
      assign mant = psat[FRAC_BITS-1 -: MANT_W];
    end else begin : g_mant_pad
      assign mant = {psat[FRAC_BITS-1:0], (MANT_W - FRAC_BITS)'(0)};
    end
  endgenerate

  // With the input clamped the biased exponent lies in 0 to 253.
  assign bexp = 9'(n_r[NST-1] + EXP_BIAS);

  always_comb begin
    res_push        = vld_r[NST-1];
    res_underflowed = cls_r[NST-1].under;
    if (cls_r[NST-1].nan || cls_r[NST-1].under) begin
      res_result_bits = '0;
    end else begin
      res_result_bits = {1'b0, bexp[7:0], mant};
    end
  end

  always_comb begin
    used_nxt = used_r;
    if (mid_pop && !out_take) begin
      used_nxt = used_r + 1'b1;
    end else if (out_take && !mid_pop) begin
      used_nxt = used_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      used_r <= used_nxt;
    end
  end

endmodule
